// ===== design/indexed_buffer_deque_core_macros.svh =====
// assertion macros shared by the deque core
`ifndef INDEXED_BUFFER_DEQUE_CORE_MACROS_SVH
`define INDEXED_BUFFER_DEQUE_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define IBDQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque core same-cycle check failed");

// next-cycle implication, off during reset
`define IBDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque core next-cycle check failed");

`endif

// ===== design/ibdq_pkg.sv =====
// types, constants and codes of the indexed buffer deque
package ibdq_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int FIELD_W    = 32;
   localparam int SIZE_W     = 16;
   localparam int IDX_W      = 8;
   localparam int ACT_W      = 4;
   localparam int ME_W       = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int POS_W      = $clog2(DEPTH);
   localparam int CMP_W      = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

   localparam logic [ME_W-1:0]   MAX_ENTRIES_RESET = ME_W'(64);
   localparam logic [SIZE_W-1:0] MAX_SIZE_RESET    = SIZE_W'(1024);

   localparam logic [CSR_IDX_W-1:0] REG_MAX_ENTRIES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SIZE    = CSR_IDX_W'(1);

   localparam logic [ACT_W-1:0] ACT_PUSH_TAIL = ACT_W'(0);
   localparam logic [ACT_W-1:0] ACT_PUSH_HEAD = ACT_W'(1);
   localparam logic [ACT_W-1:0] ACT_INSERT    = ACT_W'(2);
   localparam logic [ACT_W-1:0] ACT_POP_HEAD  = ACT_W'(3);
   localparam logic [ACT_W-1:0] ACT_POP_TAIL  = ACT_W'(4);
   localparam logic [ACT_W-1:0] ACT_REMOVE    = ACT_W'(5);
   localparam logic [ACT_W-1:0] ACT_READ      = ACT_W'(6);
   localparam logic [ACT_W-1:0] ACT_CLEAR     = ACT_W'(7);
   localparam logic [ACT_W-1:0] ACT_COUNT     = ACT_W'(8);

   typedef enum logic [2:0] {
      ST_OK,
      ST_FULL,
      ST_BAD_SIZE,
      ST_BAD_OFFS,
      ST_EMPTY,
      ST_BAD_IDX
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT
   } cell_op_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] payload;
      logic [SIZE_W-1:0]     size;
   } entry_type;

   // decoded command from the control unit to the cell row
   typedef struct packed {
      logic              ins;
      logic              rem;
      logic [POS_W-1:0]  pos;
      logic              rd_ok;
      logic [POS_W-1:0]  rd_pos;
      entry_type         load;
      status_type        status;
      logic [CNT_W-1:0]  count_next;
   } cmd_type;

   typedef struct packed {
      status_type          status;
      logic [FIELD_W-1:0]  payload;
      logic [SIZE_W-1:0]   size;
      logic [CNT_W-1:0]    count;
   } rsp_type;

endpackage

// ===== design/ibdq_cell.sv =====
// one storage cell of the shifting entry row
module ibdq_cell (
   input  logic                 clock,
   input  ibdq_pkg::cell_op_type op,
   input  ibdq_pkg::entry_type  left_in,
   input  ibdq_pkg::entry_type  right_in,
   input  ibdq_pkg::entry_type  load_in,
   output ibdq_pkg::entry_type  data_out
);

   ibdq_pkg::entry_type data_ff;
   ibdq_pkg::entry_type data_in;

   always_comb begin
      case (op)
         ibdq_pkg::CELL_LOAD:       data_in = load_in;
         ibdq_pkg::CELL_FROM_LEFT:  data_in = left_in;
         ibdq_pkg::CELL_FROM_RIGHT: data_in = right_in;
         default:                   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ===== design/ibdq_ctrl.sv =====
// command decode, limit checks, entry count and configuration registers
module ibdq_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ibdq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ibdq_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 accept,
   input  logic [ibdq_pkg::ACT_W-1:0]           action,
   input  logic signed [ibdq_pkg::IDX_W-1:0]    index,
   input  logic [ibdq_pkg::FIELD_W-1:0]         payload_in,
   input  logic [ibdq_pkg::SIZE_W-1:0]          size_in,
   output ibdq_pkg::cmd_type                    cmd
);

   localparam int CW = ibdq_pkg::CMP_W;

   logic [ibdq_pkg::ME_W-1:0]   max_entries_ff, max_entries_in;
   logic [ibdq_pkg::SIZE_W-1:0] max_size_ff, max_size_in;
   logic [ibdq_pkg::CNT_W-1:0]  count_ff;

   logic signed [CW-1:0] n_s, idx_s, lim_s, me_s, rd_s, tail_s;
   logic                 full, bad_size;

   always_comb begin
      max_entries_in = max_entries_ff;
      max_size_in    = max_size_ff;
      if (csr_we) begin
         case (csr_index)
            ibdq_pkg::REG_MAX_ENTRIES:
               max_entries_in = csr_wdata[ibdq_pkg::ME_W-1:0];
            ibdq_pkg::REG_MAX_SIZE:
               max_size_in = csr_wdata[ibdq_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      n_s    = CW'(count_ff);
      idx_s  = CW'(index);
      me_s   = CW'(max_entries_ff);
      lim_s  = ((me_s == '0) || (me_s > CW'(ibdq_pkg::DEPTH))) ?
               CW'(ibdq_pkg::DEPTH) : me_s;
      rd_s   = (idx_s >= 0) ? idx_s : (n_s + idx_s);
      tail_s = n_s - CW'(1);
      full   = (n_s >= lim_s);
      bad_size = (size_in == '0) || ((max_size_ff != '0) && (size_in > max_size_ff));

      cmd              = '0;
      cmd.status       = ibdq_pkg::ST_OK;
      cmd.load.payload = ibdq_pkg::DATA_WIDTH'(payload_in);
      cmd.load.size    = size_in;
      cmd.count_next   = count_ff;

      case (action)
         ibdq_pkg::ACT_PUSH_TAIL, ibdq_pkg::ACT_PUSH_HEAD, ibdq_pkg::ACT_INSERT: begin
            if (full) begin
               cmd.status = ibdq_pkg::ST_FULL;
            end else if (bad_size) begin
               cmd.status = ibdq_pkg::ST_BAD_SIZE;
            end else if ((action == ibdq_pkg::ACT_INSERT) &&
                         ((idx_s < 0) || (idx_s > n_s))) begin
               cmd.status = ibdq_pkg::ST_BAD_OFFS;
            end else begin
               cmd.ins = 1'b1;
               if (action == ibdq_pkg::ACT_PUSH_TAIL) begin
                  cmd.pos = count_ff[ibdq_pkg::POS_W-1:0];
               end else if (action == ibdq_pkg::ACT_INSERT) begin
                  cmd.pos = idx_s[ibdq_pkg::POS_W-1:0];
               end
            end
         end
         ibdq_pkg::ACT_POP_HEAD, ibdq_pkg::ACT_POP_TAIL, ibdq_pkg::ACT_REMOVE: begin
            if (count_ff == '0) begin
               cmd.status = ibdq_pkg::ST_EMPTY;
            end else if ((action == ibdq_pkg::ACT_REMOVE) &&
                         ((idx_s < 0) || (idx_s >= n_s))) begin
               cmd.status = ibdq_pkg::ST_BAD_IDX;
            end else begin
               cmd.rem   = 1'b1;
               cmd.rd_ok = 1'b1;
               if (action == ibdq_pkg::ACT_POP_TAIL) begin
                  cmd.pos = tail_s[ibdq_pkg::POS_W-1:0];
               end else if (action == ibdq_pkg::ACT_REMOVE) begin
                  cmd.pos = idx_s[ibdq_pkg::POS_W-1:0];
               end
            end
         end
         ibdq_pkg::ACT_READ: begin
            // an empty queue always lands here as a bad index
            if ((rd_s < 0) || (rd_s >= n_s)) begin
               cmd.status = ibdq_pkg::ST_BAD_IDX;
            end else begin
               cmd.rd_ok = 1'b1;
            end
         end
         ibdq_pkg::ACT_CLEAR: cmd.count_next = '0;
         ibdq_pkg::ACT_COUNT: ;
         default: ;
      endcase

      if (cmd.ins) begin
         cmd.count_next = count_ff + ibdq_pkg::CNT_W'(1);
      end else if (cmd.rem) begin
         cmd.count_next = count_ff - ibdq_pkg::CNT_W'(1);
      end
      cmd.rd_pos = (action == ibdq_pkg::ACT_READ) ? rd_s[ibdq_pkg::POS_W-1:0] : cmd.pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= ibdq_pkg::MAX_ENTRIES_RESET;
         max_size_ff    <= ibdq_pkg::MAX_SIZE_RESET;
         count_ff       <= '0;
      end else begin
         max_entries_ff <= max_entries_in;
         max_size_ff    <= max_size_in;
         if (accept) begin
            count_ff <= cmd.count_next;
         end
      end
   end

endmodule

// ===== design/indexed_buffer_deque_core.sv =====
// top level of the indexed buffer deque: cell row, control and result buffer
// usage
//  - req channel carries one command beat: action, index, payload_in, size_in
//  - rsp channel returns exactly one beat per command: status, payload_out,
//    size_out and the entry count after the command
//  - csr port writes max_entries (index 0) and max_size (index 1); write only
//    while no command is in flight
// timing
//  - one command per cycle while req_stall is low; the result is registered in the
//    output register, or in the skid register while the output is held
//  - insert and remove shift the row in place: cells at and after the slot take
//    from their left or right neighbor at once; read, pop and remove use one mux over the row
// back-pressure
//  - output register plus skid register let one more command be taken while
//    rsp_stall is high; req_stall rises only when both are full, order is kept
// reset
//  - synchronous: queue empty, max_entries 64, max_size 1024, no result held;
//    cell contents are not cleared and are never read before being written
module indexed_buffer_deque_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ibdq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ibdq_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ibdq_pkg::ACT_W-1:0]           req_action,
   input  logic signed [ibdq_pkg::IDX_W-1:0]    req_index,
   input  logic [ibdq_pkg::FIELD_W-1:0]         req_payload_in,
   input  logic [ibdq_pkg::SIZE_W-1:0]          req_size_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_status,
   output logic [ibdq_pkg::FIELD_W-1:0]         rsp_payload_out,
   output logic [ibdq_pkg::SIZE_W-1:0]          rsp_size_out,
   output logic [ibdq_pkg::CNT_W-1:0]           rsp_count
);

   `include "indexed_buffer_deque_core_macros.svh"

   localparam int D = ibdq_pkg::DEPTH;

   ibdq_pkg::cmd_type     cmd;
   ibdq_pkg::entry_type   cell_q [D];
   ibdq_pkg::cell_op_type cell_op [D];
   ibdq_pkg::entry_type   rd_entry;
   ibdq_pkg::rsp_type     result;
   logic                  accept;

   // result buffer: output register plus skid register
   ibdq_pkg::rsp_type main_ff, main_in, skid_ff, skid_in;
   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   logic              main_free;

   // output beat flags seen by the checks
   logic              err_beat;
   logic              no_entry_beat;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   ibdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .action     (req_action),
      .index      (req_index),
      .payload_in (req_payload_in),
      .size_in    (req_size_in),
      .cmd        (cmd)
   );

   // row of cells; entry 0 is the head
   for (genvar i = 0; i < D; i++) begin : g_cell
      always_comb begin
         cell_op[i] = ibdq_pkg::CELL_HOLD;
         if (accept && cmd.ins) begin
            // entries at and after the slot move one place toward the tail
            if (ibdq_pkg::POS_W'(i) == cmd.pos) begin
               cell_op[i] = ibdq_pkg::CELL_LOAD;
            end else if (ibdq_pkg::POS_W'(i) > cmd.pos) begin
               cell_op[i] = ibdq_pkg::CELL_FROM_LEFT;
            end
         end else if (accept && cmd.rem) begin
            // entries after the slot close the gap
            if (ibdq_pkg::POS_W'(i) >= cmd.pos) begin
               cell_op[i] = ibdq_pkg::CELL_FROM_RIGHT;
            end
         end
      end

      ibdq_cell u_cell (
         .clock    (clock),
         .op       (cell_op[i]),
         .left_in  ((i == 0) ? cmd.load : cell_q[(i == 0) ? 0 : i - 1]),
         .right_in (cell_q[(i == D - 1) ? i : i + 1]),
         .load_in  (cmd.load),
         .data_out (cell_q[i])
      );
   end

   // entry picked by read, pop or remove, taken before the row shifts
   assign rd_entry = cell_q[cmd.rd_pos];

   always_comb begin
      result.status  = cmd.status;
      result.count   = cmd.count_next;
      result.payload = cmd.rd_ok ? ibdq_pkg::FIELD_W'(rd_entry.payload) : '0;
      result.size    = cmd.rd_ok ? rd_entry.size : '0;
   end

   assign main_free = !main_valid_ff || !rsp_stall;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            main_in       = result;
            main_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (accept) begin
         // output held by the receiver: park the new beat
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = main_valid_ff;
   assign rsp_status      = main_ff.status;
   assign rsp_payload_out = main_ff.payload;
   assign rsp_size_out    = main_ff.size;
   assign rsp_count       = main_ff.count;

   assign err_beat      = main_valid_ff && (main_ff.status != ibdq_pkg::ST_OK);
   assign no_entry_beat = (main_ff.payload == '0) && (main_ff.size == '0);

   // skid only fills behind a held output beat
   `IBDQ_ASSERT_IMPL(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   // after a taken command the output holds a valid result beat next cycle
   `IBDQ_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, main_valid_ff)
   // failed commands return no entry
   `IBDQ_ASSERT_IMPL(a_err_zero_data, clock, reset, err_beat, no_entry_beat)
   // count never exceeds storage
   `IBDQ_ASSERT_IMPL(a_count_bound, clock, reset, main_valid_ff, main_ff.count <= ibdq_pkg::CNT_W'(D))

endmodule

// ===== tb/indexed_buffer_deque_core_tb.sv =====
// testbench for the indexed buffer deque core: directed and random commands checked per beat
`timescale 1ns / 1ps

module indexed_buffer_deque_core_tb;
   import ibdq_pkg::*;

   // generous bound on the length of a correct run
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;
   // action codes nine to fifteen are ignored by the block
   localparam logic [ACT_W-1:0] ACT_UNUSED_TOP = ACT_W'(15);

   // shape of one stretch of random traffic
   typedef enum int {
      RUN_GROW,
      RUN_SHRINK,
      RUN_MIXED,
      RUN_NOISE
   } run_kind_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;
   logic                     req_valid;
   logic                     req_stall;
   logic [ACT_W-1:0]         req_action;
   logic signed [IDX_W-1:0]  req_index;
   logic [FIELD_W-1:0]       req_payload_in;
   logic [SIZE_W-1:0]        req_size_in;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [2:0]               rsp_status;
   logic [FIELD_W-1:0]       rsp_payload_out;
   logic [SIZE_W-1:0]        rsp_size_out;
   logic [CNT_W-1:0]         rsp_count;

   // shadow copy of the deque contents and its two registers
   logic [DATA_WIDTH-1:0]    shadow_payload [DEPTH];
   logic [SIZE_W-1:0]        shadow_size [DEPTH];
   int                       shadow_count;
   logic [ME_W-1:0]          cfg_max_entries;
   logic [SIZE_W-1:0]        cfg_max_size;

   // results owed by the block, oldest first
   rsp_type                  results_due[$];

   int                       send_idle_pct;
   int                       recv_idle_pct;
   int                       result_mismatches;
   int                       cycle_count;

   indexed_buffer_deque_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_index       (req_index),
      .req_payload_in  (req_payload_in),
      .req_size_in     (req_size_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_payload_out (rsp_payload_out),
      .rsp_size_out    (rsp_size_out),
      .rsp_count       (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // shadow deque: effective limit and one command applied
   // ---------------------------------------------------------------------------

   // limit zero or anything past the storage means the storage depth
   function automatic int entry_limit();
      if (cfg_max_entries == 0 || cfg_max_entries > DEPTH)
         return DEPTH;
      return int'(cfg_max_entries);
   endfunction

   // applies one accepted command to the shadow deque and returns its result beat
   function automatic rsp_type apply_deque_command(input logic [ACT_W-1:0] act,
                                                   input logic signed [IDX_W-1:0] idx,
                                                   input logic [FIELD_W-1:0] pay,
                                                   input logic [SIZE_W-1:0] sz);
      rsp_type r;
      int      n;
      int      sidx;
      int      pos;
      int      i;
      n = shadow_count;
      sidx = idx;
      r.status = ST_OK;
      r.payload = '0;
      r.size = '0;
      case (act)
         ACT_PUSH_TAIL, ACT_PUSH_HEAD, ACT_INSERT: begin
            // full wins over bad size, bad size over bad offset
            if (n >= entry_limit())
               r.status = ST_FULL;
            else if (sz == 0 || (cfg_max_size != 0 && sz > cfg_max_size))
               r.status = ST_BAD_SIZE;
            else if (act == ACT_INSERT && (sidx < 0 || sidx > n))
               r.status = ST_BAD_OFFS;
            else begin
               pos = (act == ACT_PUSH_TAIL) ? n : (act == ACT_PUSH_HEAD) ? 0 : sidx;
               for (i = n; i > pos; i--) begin
                  shadow_payload[i] = shadow_payload[i-1];
                  shadow_size[i] = shadow_size[i-1];
               end
               shadow_payload[pos] = pay[DATA_WIDTH-1:0];
               shadow_size[pos] = sz;
               shadow_count++;
            end
         end
         ACT_POP_HEAD, ACT_POP_TAIL, ACT_REMOVE: begin
            if (n == 0)
               r.status = ST_EMPTY;
            else if (act == ACT_REMOVE && (sidx < 0 || sidx >= n))
               r.status = ST_BAD_IDX;
            else begin
               pos = (act == ACT_POP_HEAD) ? 0 : (act == ACT_POP_TAIL) ? n - 1 : sidx;
               r.payload = FIELD_W'(shadow_payload[pos]);
               r.size = shadow_size[pos];
               for (i = pos; i + 1 < n; i++) begin
                  shadow_payload[i] = shadow_payload[i+1];
                  shadow_size[i] = shadow_size[i+1];
               end
               shadow_count--;
            end
         end
         ACT_READ: begin
            // negative index counts back from the tail; empty is always bad index
            pos = (sidx >= 0) ? sidx : n + sidx;
            if (pos < 0 || pos >= n)
               r.status = ST_BAD_IDX;
            else begin
               r.payload = FIELD_W'(shadow_payload[pos]);
               r.size = shadow_size[pos];
            end
         end
         ACT_CLEAR: shadow_count = 0;
         default: ;
      endcase
      r.count = CNT_W'(shadow_count);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // drivers: inputs change on the falling edge, handshakes seen on the rising edge
   // ---------------------------------------------------------------------------

   // one request beat, with random idle cycles ahead of it
   task automatic send_item(input logic [ACT_W-1:0] act, input logic signed [IDX_W-1:0] idx,
                            input logic [FIELD_W-1:0] pay, input logic [SIZE_W-1:0] sz);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         // junk on the payload while not valid must be ignored
         req_action <= ACT_W'($urandom);
         req_index <= IDX_W'($urandom);
         req_payload_in <= $urandom;
         req_size_in <= SIZE_W'($urandom);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_index <= idx;
      req_payload_in <= pay;
      req_size_in <= sz;
      do @(posedge clock); while (req_stall);
      results_due.push_back(apply_deque_command(act, idx, pay, sz));
   endtask

   // drop valid and hold off until every owed beat has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // register write; callers make sure the block is idle first
   task automatic write_reg(input logic [CSR_IDX_W-1:0] which,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      if (which == REG_MAX_ENTRIES)
         cfg_max_entries = value[ME_W-1:0];
      else
         cfg_max_size = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // writes both registers; upper bits of the entry limit word may carry junk
   task automatic set_limits(input logic [ME_W-1:0] entries, input logic [SIZE_W-1:0] bytes);
      logic [CSR_DATA_W-ME_W-1:0] junk;
      junk = ($urandom_range(1) == 0) ? '0 : (CSR_DATA_W-ME_W)'($urandom);
      wait_drained();
      write_reg(REG_MAX_ENTRIES, {junk, entries});
      write_reg(REG_MAX_SIZE, bytes);
   endtask

   // ---------------------------------------------------------------------------
   // random field pickers that follow the current shadow state
   // ---------------------------------------------------------------------------

   function automatic logic [SIZE_W-1:0] good_size();
      int roll;
      roll = $urandom_range(9);
      if (cfg_max_size == 0)
         return (roll == 0) ? '1 : SIZE_W'($urandom_range(1, 65535));
      if (roll == 0)
         return cfg_max_size;
      if (roll == 1)
         return SIZE_W'(1);
      return SIZE_W'($urandom_range(1, cfg_max_size));
   endfunction

   function automatic logic [SIZE_W-1:0] bad_size();
      if (cfg_max_size == 0 || cfg_max_size == '1 || $urandom_range(1) == 0)
         return '0;
      return SIZE_W'($urandom_range(cfg_max_size + 1, 65535));
   endfunction

   // one random command shaped by the kind of run; tells whether it was a real command
   task automatic send_shaped(input run_kind_type kind, output bit counted);
      logic [ACT_W-1:0]        act;
      logic signed [IDX_W-1:0] idx;
      logic [FIELD_W-1:0]      pay;
      logic [SIZE_W-1:0]       sz;
      int                      n;
      int                      roll;
      int                      k;
      n = shadow_count;
      roll = $urandom_range(99);
      pay = $urandom;
      sz = good_size();
      idx = IDX_W'($urandom);
      case (kind)
         RUN_GROW:
            act = (roll < 45) ? ACT_PUSH_TAIL : (roll < 70) ? ACT_PUSH_HEAD :
                  (roll < 90) ? ACT_INSERT : ACT_W'($urandom_range(0, 8));
         RUN_SHRINK:
            act = (roll < 30) ? ACT_POP_HEAD : (roll < 60) ? ACT_POP_TAIL :
                  (roll < 85) ? ACT_REMOVE : ACT_READ;
         RUN_MIXED:
            act = ACT_W'($urandom_range(0, 8));
         default: begin
            act = ACT_W'($urandom);
            sz = SIZE_W'($urandom);
         end
      endcase
      if (kind != RUN_NOISE) begin
         // mostly legal positions for the current fill level
         if (act == ACT_INSERT)
            idx = IDX_W'($urandom_range(0, n));
         else if (act == ACT_REMOVE && n > 0)
            idx = IDX_W'($urandom_range(0, n - 1));
         else if (act == ACT_READ && n > 0) begin
            if ($urandom_range(1) == 0)
               idx = IDX_W'($urandom_range(0, n - 1));
            else begin
               k = $urandom_range(1, n);
               idx = IDX_W'(-k);
            end
         end
         // now and then a broken field: bad length, or a position just off the edge or at an extreme
         roll = $urandom_range(19);
         if (roll == 0)
            sz = bad_size();
         else if (roll == 1) begin
            case ($urandom_range(5))
               0: idx = IDX_W'(n);
               1: idx = IDX_W'(n + 1);
               2: idx = IDX_W'(-1);
               3: idx = IDX_W'(-(n + 1));
               4: idx = 8'sh7f;
               default: idx = 8'sh80;
            endcase
         end
      end
      send_item(act, idx, pay, sz);
      counted = (act <= ACT_COUNT);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // every take or read on an empty deque, index zero read included
   task automatic test_empty_queue();
      send_item(ACT_READ, 8'sd0, 32'h0, 16'd1);
      send_item(ACT_READ, -8'sd1, 32'h0, 16'd1);
      send_item(ACT_POP_HEAD, 8'sd0, 32'h0, 16'd1);
      send_item(ACT_POP_TAIL, 8'sd0, 32'h0, 16'd1);
      send_item(ACT_REMOVE, 8'sd0, 32'h0, 16'd1);
   endtask

   // length checks at the reset limit, payload extremes, insert offsets
   task automatic test_push_checks();
      send_item(ACT_PUSH_TAIL, 8'sd0, 32'h1234_5678, 16'd0);
      send_item(ACT_PUSH_TAIL, 8'sd0, 32'h1234_5678, 16'd1025);
      send_item(ACT_PUSH_TAIL, 8'sd0, 32'hFFFF_FFFF, 16'd1024);
      send_item(ACT_PUSH_HEAD, 8'sd0, 32'h0000_0000, 16'd1);
      send_item(ACT_INSERT, 8'sd1, 32'hA5A5_A5A5, 16'h0155);
      // bad size is reported ahead of bad offset
      send_item(ACT_INSERT, -8'sd1, 32'h0, 16'd0);
      send_item(ACT_INSERT, -8'sd1, 32'h0, 16'd8);
      send_item(ACT_INSERT, 8'sd4, 32'h0, 16'd8);
      send_item(ACT_INSERT, 8'sd3, 32'h5A5A_5A5A, 16'd2);
   endtask

   // signed reads from both ends and removal edges on a four-entry deque
   task automatic test_signed_reads();
      send_item(ACT_READ, -8'sd1, 32'h0, 16'd0);
      send_item(ACT_READ, -8'sd4, 32'h0, 16'd0);
      send_item(ACT_READ, -8'sd5, 32'h0, 16'd0);
      send_item(ACT_READ, 8'sd4, 32'h0, 16'd0);
      send_item(ACT_REMOVE, -8'sd1, 32'h0, 16'd0);
      send_item(ACT_REMOVE, 8'sd1, 32'h0, 16'd0);
      send_item(ACT_POP_HEAD, 8'sd0, 32'h0, 16'd0);
      send_item(ACT_POP_TAIL, 8'sd0, 32'h0, 16'd0);
   endtask

   // ignored code, count query, clear
   task automatic test_clear_and_unused();
      send_item(ACT_UNUSED_TOP, 8'sd0, 32'hDEAD_BEEF, 16'd3);
      send_item(ACT_COUNT, 8'sd0, 32'h0, 16'd0);
      send_item(ACT_CLEAR, 8'sd0, 32'h0, 16'd0);
   endtask

   // limit of one entry: full is reported ahead of bad size
   task automatic test_entry_limit();
      set_limits(ME_W'(1), MAX_SIZE_RESET);
      send_item(ACT_PUSH_TAIL, 8'sd0, 32'h0BAD_F00D, 16'd7);
      send_item(ACT_PUSH_HEAD, 8'sd0, 32'h0, 16'd0);
      send_item(ACT_INSERT, 8'sd0, 32'h0, 16'd7);
   endtask

   // runs that fill to the limit, drain to empty, mix commands or throw junk
   task automatic test_random_traffic(input logic [ME_W-1:0] entries,
                                      input logic [SIZE_W-1:0] bytes, input int n_items);
      int           sent;
      int           run_len;
      int           roll;
      int           k;
      run_kind_type kind;
      bit           counted;
      set_limits(entries, bytes);
      sent = 0;
      while (sent < n_items) begin
         // occasional hold-off until the result pipe is empty
         if ($urandom_range(99) < 4)
            wait_drained();
         roll = $urandom_range(99);
         if (roll < 35) begin
            kind = RUN_GROW;
            run_len = entry_limit() - shadow_count + $urandom_range(1, 3);
         end else if (roll < 65) begin
            kind = RUN_SHRINK;
            run_len = shadow_count + $urandom_range(1, 3);
         end else if (roll < 90) begin
            kind = RUN_MIXED;
            run_len = $urandom_range(8, 30);
         end else begin
            kind = RUN_NOISE;
            run_len = $urandom_range(2, 6);
         end
         // a run is cut short once the budget of commands is spent
         for (k = 0; k < run_len && sent < n_items; k++) begin
            send_shaped(kind, counted);
            if (counted)
               sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // result side: random stall, one compare per accepted beat
   // ---------------------------------------------------------------------------

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            result_mismatches++;
            if (result_mismatches <= REPORT_LIMIT)
               $display("unexpected result beat: status %0d payload %h size %0d count %0d",
                        rsp_status, rsp_payload_out, rsp_size_out, rsp_count);
         end else begin
            want = results_due.pop_front();
            if (rsp_status !== want.status || rsp_payload_out !== want.payload ||
                rsp_size_out !== want.size || rsp_count !== want.count) begin
               result_mismatches++;
               if (result_mismatches <= REPORT_LIMIT)
                  $display("result mismatch: want status %0d payload %h size %0d count %0d, %s",
                           want.status, want.payload, want.size, want.count,
                           $sformatf("got status %0d payload %h size %0d count %0d",
                                     rsp_status, rsp_payload_out, rsp_size_out, rsp_count));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // sequence of tests
   // ---------------------------------------------------------------------------

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_action = '0;
      req_index = '0;
      req_payload_in = '0;
      req_size_in = '0;
      rsp_stall = 1'b0;
      shadow_count = 0;
      cfg_max_entries = MAX_ENTRIES_RESET;
      cfg_max_size = MAX_SIZE_RESET;
      result_mismatches = 0;
      cycle_count = 0;
      // sender idles rarely, receiver often
      send_idle_pct = 11;
      recv_idle_pct = 68;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_push_checks();
      test_signed_reads();
      test_clear_and_unused();
      test_entry_limit();

      // reset limits again, then no limit at all (zero means storage depth)
      test_random_traffic(MAX_ENTRIES_RESET, MAX_SIZE_RESET, 145);
      test_random_traffic(ME_W'(0), SIZE_W'(0), 145);

      // roles swapped: sender idles often, receiver rarely
      send_idle_pct = 68;
      recv_idle_pct = 11;
      // limit past the storage is clamped; largest and smallest length limits
      test_random_traffic(ME_W'(127), SIZE_W'(65535), 140);
      test_random_traffic(ME_W'(1), SIZE_W'(1), 140);

      // back to back, no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(ME_W'(7), SIZE_W'(16), 140);
      test_random_traffic(ME_W'(64), SIZE_W'(300), 140);

      wait_drained();
      repeat (8) @(posedge clock);
      if (result_mismatches == 0 && results_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
